FILE: hw/rtl/voxel_sand_cavity_face_counter_defines.svh
// Assertion macros used by the checker of the face counter.
`ifndef VOXEL_SAND_CAVITY_FACE_COUNTER_DEFINES_SVH
`define VOXEL_SAND_CAVITY_FACE_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define VSCFC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define VSCFC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/vscfc_pkg.sv
package vscfc_pkg;

   localparam int VOXEL_W      = 8;
   localparam int SIZE_W       = 9;
   localparam int LEAK_W       = 32;
   localparam int FACE_W       = 26;
   localparam int NEW_W        = 2;
   localparam int LEAK_TOTAL_W = FACE_W + LEAK_W;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [FACE_W-1:0] FACE_MAX = '1;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type REG_SIZE_X        = 2'd0;
   localparam csr_index_type REG_SIZE_Y        = 2'd1;
   localparam csr_index_type REG_SIZE_Z        = 2'd2;
   localparam csr_index_type REG_LEAK_PER_FACE = 2'd3;

   // What the scan stage hands to the tally stage along with the ring reads.
   typedef struct packed {
      logic sand;
      logic prev_sand;
      logic chk_z;
      logic chk_y;
      logic chk_x;
      logic first;
      logic last;
   } voxel_info_type;

endpackage

FILE: hw/rtl/vscfc_req_if.sv
interface vscfc_req_if;
   import vscfc_pkg::*;

   logic               valid;
   logic               ready;
   logic [VOXEL_W-1:0] voxel;

   modport source (output valid, output voxel, input ready);
   modport sink (input valid, input voxel, output ready);
endinterface

FILE: hw/rtl/vscfc_rsp_if.sv
interface vscfc_rsp_if;
   import vscfc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    is_sand;
   logic [NEW_W-1:0]        new_faces;
   logic [FACE_W-1:0]       face_total;
   logic [LEAK_TOTAL_W-1:0] leak_total;
   logic                    last;

   modport source (output valid, output is_sand, output new_faces, output face_total,
                   output leak_total, output last, input ready);
   modport sink (input valid, input is_sand, input new_faces, input face_total,
                 input leak_total, input last, output ready);
endinterface

FILE: hw/rtl/vscfc_ram.sv
module vscfc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read-first: a read and a write of one address at one edge return the old data
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/vscfc_scan.sv
module vscfc_scan #(
   parameter int MAX_DIM = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  vscfc_pkg::csr_index_type            csr_index,
   input  logic [vscfc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                req_valid,
   input  logic [vscfc_pkg::VOXEL_W-1:0]       req_voxel,
   output logic                                req_ready,
   output logic                                ring_access,
   output logic                                ring_wdata,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  ring_addr,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  row_raddr,
   input  logic                                s1_take_ready,
   output logic                                s1_valid,
   output vscfc_pkg::voxel_info_type           s1_info,
   output logic [vscfc_pkg::LEAK_W-1:0]        leak_per_face
);
   import vscfc_pkg::*;

   localparam int POS_W  = $clog2(MAX_DIM);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

   // out-of-range sizes clamp into 1..MAX_DIM
   function automatic logic [DIM_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
      logic [DIM_W-1:0] result;
      if (raw == '0) begin
         result = DIM_W'(1);
      end else if (32'(raw) > 32'(MAX_DIM)) begin
         result = DIM_W'(MAX_DIM);
      end else begin
         result = DIM_W'(raw);
      end
      return result;
   endfunction

   logic [DIM_W-1:0]  size_x_ff, size_x_in;
   logic [DIM_W-1:0]  size_y_ff, size_y_in;
   logic [DIM_W-1:0]  size_z_ff, size_z_in;
   logic [LEAK_W-1:0] leak_ff, leak_in;
   logic [POS_W-1:0]  pos_x_ff, pos_x_in;
   logic [POS_W-1:0]  pos_y_ff, pos_y_in;
   logic [POS_W-1:0]  pos_z_ff, pos_z_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              prev_sand_ff, prev_sand_in;
   logic              v1_ff, v1_in;
   voxel_info_type    info_ff, info_in;

   logic fire;
   logic sand;
   logic end_x, end_y, end_z;

   assign req_ready = !v1_ff || s1_take_ready;
   assign fire      = req_valid && req_ready;
   assign sand      = |req_voxel;

   assign end_z = (DIM_W'(pos_z_ff) + DIM_W'(1)) == size_z_ff;
   assign end_y = (DIM_W'(pos_y_ff) + DIM_W'(1)) == size_y_ff;
   assign end_x = (DIM_W'(pos_x_ff) + DIM_W'(1)) == size_x_ff;

   always_comb begin
      size_x_in    = size_x_ff;
      size_y_in    = size_y_ff;
      size_z_in    = size_z_ff;
      leak_in      = leak_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;
      idx_in       = idx_ff;
      prev_sand_in = prev_sand_ff;
      info_in      = info_ff;
      v1_in        = v1_ff;

      if (fire) begin
         v1_in = 1'b1;
      end else if (s1_take_ready) begin
         v1_in = 1'b0;
      end

      if (fire) begin
         info_in.sand      = sand;
         info_in.prev_sand = prev_sand_ff;
         info_in.chk_z     = pos_z_ff != '0;
         info_in.chk_y     = pos_y_ff != '0;
         info_in.chk_x     = pos_x_ff != '0;
         info_in.first     = (pos_x_ff == '0) && (pos_y_ff == '0) && (pos_z_ff == '0);
         info_in.last      = end_x && end_y && end_z;
         prev_sand_in      = sand;

         if (!end_z) begin
            pos_z_in = pos_z_ff + POS_W'(1);
         end else begin
            pos_z_in = '0;
            if (!end_y) begin
               pos_y_in = pos_y_ff + POS_W'(1);
            end else begin
               pos_y_in = '0;
               pos_x_in = end_x ? '0 : pos_x_ff + POS_W'(1);
            end
         end
         // ring address runs linearly through one plane
         idx_in = (end_z && end_y) ? '0 : idx_ff + ADDR_W'(1);
      end

      if (csr_we) begin
         unique case (csr_index)
            REG_SIZE_X: begin
               size_x_in = eff_size(csr_wdata[SIZE_W-1:0]);
            end
            REG_SIZE_Y: begin
               size_y_in = eff_size(csr_wdata[SIZE_W-1:0]);
            end
            REG_SIZE_Z: begin
               size_z_in = eff_size(csr_wdata[SIZE_W-1:0]);
            end
            REG_LEAK_PER_FACE: begin
               leak_in = csr_wdata[LEAK_W-1:0];
            end
         endcase
         if (csr_index != REG_LEAK_PER_FACE) begin
            pos_x_in = '0;
            pos_y_in = '0;
            pos_z_in = '0;
            idx_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= DIM_W'(1);
         size_y_ff <= DIM_W'(1);
         size_z_ff <= DIM_W'(1);
         leak_ff   <= '0;
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         pos_z_ff  <= '0;
         idx_ff    <= '0;
         v1_ff     <= 1'b0;
      end else begin
         size_x_ff <= size_x_in;
         size_y_ff <= size_y_in;
         size_z_ff <= size_z_in;
         leak_ff   <= leak_in;
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
         pos_z_ff  <= pos_z_in;
         idx_ff    <= idx_in;
         v1_ff     <= v1_in;
      end
      prev_sand_ff <= prev_sand_in;
      info_ff      <= info_in;
   end

   // the sand bit goes into the ring at accept; the previous plane's bit at the
   // same address comes back through the read-first port
   assign ring_access   = fire;
   assign ring_wdata    = sand;
   assign ring_addr     = idx_ff;
   assign row_raddr     = idx_ff - ADDR_W'(size_z_ff);
   assign s1_valid      = v1_ff;
   assign s1_info       = info_ff;
   assign leak_per_face = leak_ff;

endmodule

FILE: hw/rtl/vscfc_tally.sv
module vscfc_tally (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  s1_valid,
   input  vscfc_pkg::voxel_info_type             s1_info,
   input  logic                                  plane_bit,
   input  logic                                  row_bit,
   input  logic [vscfc_pkg::LEAK_W-1:0]          leak_per_face,
   output logic                                  s1_take_ready,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_is_sand,
   output logic [vscfc_pkg::NEW_W-1:0]           rsp_new_faces,
   output logic [vscfc_pkg::FACE_W-1:0]          rsp_face_total,
   output logic [vscfc_pkg::LEAK_TOTAL_W-1:0]    rsp_leak_total,
   output logic                                  rsp_last
);
   import vscfc_pkg::*;

   logic                    en2, en3, move1, move2;
   logic [NEW_W-1:0]        nf;
   logic [FACE_W-1:0]       base;
   logic [FACE_W:0]         sum;
   logic [FACE_W-1:0]       total;

   logic                    v2_ff;
   logic                    sand2_ff;
   logic [NEW_W-1:0]        nf2_ff;
   logic [FACE_W-1:0]       total2_ff;
   logic                    last2_ff;

   logic                    v3_ff;
   logic                    sand3_ff;
   logic [NEW_W-1:0]        nf3_ff;
   logic [FACE_W-1:0]       total3_ff;
   logic [LEAK_TOTAL_W-1:0] leak3_ff;
   logic                    last3_ff;

   assign en3           = !v3_ff || rsp_ready;
   assign en2           = !v2_ff || en3;
   assign s1_take_ready = en2;
   assign move1         = s1_valid && en2;
   assign move2         = v2_ff && en3;

   assign nf = NEW_W'(s1_info.chk_z && (s1_info.sand ^ s1_info.prev_sand))
             + NEW_W'(s1_info.chk_y && (s1_info.sand ^ row_bit))
             + NEW_W'(s1_info.chk_x && (s1_info.sand ^ plane_bit));

   // total2_ff doubles as the running count; the first voxel starts it over
   assign base  = s1_info.first ? '0 : total2_ff;
   assign sum   = {1'b0, base} + (FACE_W + 1)'(nf);
   assign total = sum[FACE_W] ? FACE_MAX : sum[FACE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en2) begin
            v2_ff <= s1_valid;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
      if (move1) begin
         sand2_ff  <= s1_info.sand;
         nf2_ff    <= nf;
         total2_ff <= total;
         last2_ff  <= s1_info.last;
      end
      if (move2) begin
         sand3_ff  <= sand2_ff;
         nf3_ff    <= nf2_ff;
         total3_ff <= total2_ff;
         leak3_ff  <= LEAK_TOTAL_W'(total2_ff) * LEAK_TOTAL_W'(leak_per_face);
         last3_ff  <= last2_ff;
      end
   end

   assign rsp_valid      = v3_ff;
   assign rsp_is_sand    = sand3_ff;
   assign rsp_new_faces  = nf3_ff;
   assign rsp_face_total = total3_ff;
   assign rsp_leak_total = leak3_ff;
   assign rsp_last       = last3_ff;

endmodule

FILE: hw/rtl/voxel_sand_cavity_face_counter.sv
// Path: an accepted voxel is registered with its ring reads in the scan stage, then
// passes the tally register and the leak multiply register before its result shows.
// Throughput: one voxel per cycle while results are taken, with the two plane-ring memories
// each having one read and one write port, and the 26x32 leak multiply in its own stage.
// Reset: position and valids clear, sizes go to 1 and leak to 0; the face count restarts
// with the first voxel; the plane ring is not cleared and holds nothing valid until written.
module voxel_sand_cavity_face_counter #(
   parameter int MAX_DIM = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  vscfc_pkg::csr_index_type          csr_index,
   input  logic [vscfc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   vscfc_req_if.sink                         req_chan,
   vscfc_rsp_if.source                       rsp_chan
);
   import vscfc_pkg::*;

   localparam int RING_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W     = $clog2(RING_DEPTH);

   logic              ring_access;
   logic              ring_wdata;
   logic [ADDR_W-1:0] ring_addr;
   logic [ADDR_W-1:0] row_raddr;
   logic              plane_bit;
   logic              row_bit;
   logic              s1_take_ready;
   logic              s1_valid;
   voxel_info_type    s1_info;
   logic [LEAK_W-1:0] leak_per_face;

   vscfc_scan #(
      .MAX_DIM (MAX_DIM)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_chan.valid),
      .req_voxel     (req_chan.voxel),
      .req_ready     (req_chan.ready),
      .ring_access   (ring_access),
      .ring_wdata    (ring_wdata),
      .ring_addr     (ring_addr),
      .row_raddr     (row_raddr),
      .s1_take_ready (s1_take_ready),
      .s1_valid      (s1_valid),
      .s1_info       (s1_info),
      .leak_per_face (leak_per_face)
   );

   // two copies of the ring, written alike: one reads the previous plane, one the previous row
   vscfc_ram #(
      .WIDTH (1),
      .DEPTH (RING_DEPTH)
   ) u_ring_plane (
      .clock (clock),
      .we    (ring_access),
      .waddr (ring_addr),
      .wdata (ring_wdata),
      .re    (ring_access),
      .raddr (ring_addr),
      .rdata (plane_bit)
   );

   vscfc_ram #(
      .WIDTH (1),
      .DEPTH (RING_DEPTH)
   ) u_ring_row (
      .clock (clock),
      .we    (ring_access),
      .waddr (ring_addr),
      .wdata (ring_wdata),
      .re    (ring_access),
      .raddr (row_raddr),
      .rdata (row_bit)
   );

   vscfc_tally u_tally (
      .clock          (clock),
      .reset          (reset),
      .s1_valid       (s1_valid),
      .s1_info        (s1_info),
      .plane_bit      (plane_bit),
      .row_bit        (row_bit),
      .leak_per_face  (leak_per_face),
      .s1_take_ready  (s1_take_ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_is_sand    (rsp_chan.is_sand),
      .rsp_new_faces  (rsp_chan.new_faces),
      .rsp_face_total (rsp_chan.face_total),
      .rsp_leak_total (rsp_chan.leak_total),
      .rsp_last       (rsp_chan.last)
   );

endmodule

FILE: hw/rtl/vscfc_checker.sv
`include "voxel_sand_cavity_face_counter_defines.svh"

module vscfc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 csr_we,
   input vscfc_pkg::csr_index_type             csr_index,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_is_sand,
   input logic [vscfc_pkg::NEW_W-1:0]          rsp_new_faces,
   input logic [vscfc_pkg::FACE_W-1:0]         rsp_face_total,
   input logic [vscfc_pkg::LEAK_TOTAL_W-1:0]   rsp_leak_total,
   input logic                                 rsp_last
);
   import vscfc_pkg::*;

   logic              req_fire, rsp_fire;
   logic [2:0]        pending_ff, pending_in;
   logic              restart_ff, restart_in;
   logic [FACE_W-1:0] prev_total_ff, prev_total_in;
   logic [FACE_W:0]   sum;
   logic [FACE_W-1:0] expect_total;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pending_in    = pending_ff + 3'(req_fire) - 3'(rsp_fire);
      restart_in    = restart_ff;
      prev_total_in = prev_total_ff;
      if (rsp_fire) begin
         restart_in    = rsp_last;
         prev_total_in = rsp_face_total;
      end
      if (csr_we && (csr_index != REG_LEAK_PER_FACE)) begin
         restart_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         restart_ff <= 1'b1;
      end else begin
         pending_ff <= pending_in;
         restart_ff <= restart_in;
      end
      prev_total_ff <= prev_total_in;
   end

   // a new volume starts from zero, otherwise the count grows by new_faces
   assign sum          = {1'b0, (restart_ff ? '0 : prev_total_ff)} + (FACE_W + 1)'(rsp_new_faces);
   assign expect_total = sum[FACE_W] ? FACE_MAX : sum[FACE_W-1:0];

   `VSCFC_ASSERT_NXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid, "result valid after reset")
   `VSCFC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_is_sand) && $stable(rsp_new_faces) && $stable(rsp_face_total) && $stable(rsp_leak_total) && $stable(rsp_last), "stalled result changed")
   `VSCFC_ASSERT_IMP(a_no_invented, clock, reset, rsp_valid, pending_ff != '0, "result without a pending voxel")
   `VSCFC_ASSERT_IMP(a_face_tally, clock, reset, rsp_fire, rsp_face_total == expect_total, "face total does not follow new faces")

endmodule

bind voxel_sand_cavity_face_counter vscfc_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .csr_we         (csr_we),
   .csr_index      (csr_index),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_is_sand    (rsp_chan.is_sand),
   .rsp_new_faces  (rsp_chan.new_faces),
   .rsp_face_total (rsp_chan.face_total),
   .rsp_leak_total (rsp_chan.leak_total),
   .rsp_last       (rsp_chan.last)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import vscfc_pkg::*;

   localparam int DIM_MAX      = 256;
   localparam int PLANE_SLOTS  = DIM_MAX * DIM_MAX;
   localparam int RANDOM_ITEMS = 1750;
   localparam int DRAIN_LIMIT  = 20000;

   // 2x2x2 checkerboard: the far corner differs from all three earlier neighbors
   localparam logic [VOXEL_W-1:0] CHECKER [8] =
      '{8'h00, 8'h01, 8'h80, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h7F};

   typedef struct packed {
      logic                    is_sand;
      logic [NEW_W-1:0]        new_faces;
      logic [FACE_W-1:0]       face_total;
      logic [LEAK_TOTAL_W-1:0] leak_total;
      logic                    last;
   } face_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   vscfc_req_if req_bus ();
   vscfc_rsp_if rsp_bus ();

   voxel_sand_cavity_face_counter uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   always #5 clock = ~clock;

   // mirrored scan state
   logic [SIZE_W-1:0] dim_raw [3];
   logic [LEAK_W-1:0] leak_rate;
   bit                sand_plane [PLANE_SLOTS];
   int unsigned       at_x, at_y, at_z;
   logic [FACE_W-1:0] face_count;

   logic [VOXEL_W-1:0] voxel_queue [$];
   face_result_type    face_expect [$];
   face_result_type    want;
   int unsigned        fault_count = 0;
   int unsigned        result_count = 0;
   int unsigned        tx_wait, rx_wait;
   bit                 tx_calm, rx_calm, rx_hold;

   function automatic int unsigned eff_dim(logic [SIZE_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > DIM_MAX) return DIM_MAX;
      return raw;
   endfunction

   function automatic void clear_scan();
      at_x = 0;
      at_y = 0;
      at_z = 0;
      face_count = '0;
   endfunction

   function automatic face_result_type scan_voxel(logic [VOXEL_W-1:0] voxel);
      face_result_type r;
      int unsigned     sx, sy, sz, slot, nf;
      bit              sand;
      sx = eff_dim(dim_raw[0]);
      sy = eff_dim(dim_raw[1]);
      sz = eff_dim(dim_raw[2]);
      sand = (voxel != '0);
      nf = 0;
      if (at_x == 0 && at_y == 0 && at_z == 0) face_count = '0;
      slot = at_y * sz + at_z;
      if (at_z > 0) nf += sand ^ sand_plane[slot - 1];
      if (at_y > 0) nf += sand ^ sand_plane[slot - sz];
      if (at_x > 0) nf += sand ^ sand_plane[slot];
      sand_plane[slot] = sand;
      if (32'(face_count) + nf > 32'(FACE_MAX)) face_count = FACE_MAX;
      else face_count = face_count + FACE_W'(nf);
      r.is_sand    = sand;
      r.new_faces  = NEW_W'(nf);
      r.face_total = face_count;
      r.leak_total = LEAK_TOTAL_W'(face_count) * LEAK_TOTAL_W'(leak_rate);
      r.last       = (at_x + 1 >= sx) && (at_y + 1 >= sy) && (at_z + 1 >= sz);
      if (at_z + 1 < sz) begin
         at_z++;
      end else begin
         at_z = 0;
         if (at_y + 1 < sy) begin
            at_y++;
         end else begin
            at_y = 0;
            at_x = (at_x + 1 < sx) ? at_x + 1 : 0;
         end
      end
      return r;
   endfunction

   function automatic logic [LEAK_W-1:0] pick_leak();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic report_fault(string what);
      fault_count++;
      if (fault_count <= 10) $display("%0t: %s", $time, what);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_SIZE_X: begin
            dim_raw[0] = data[SIZE_W-1:0];
            clear_scan();
         end
         REG_SIZE_Y: begin
            dim_raw[1] = data[SIZE_W-1:0];
            clear_scan();
         end
         REG_SIZE_Z: begin
            dim_raw[2] = data[SIZE_W-1:0];
            clear_scan();
         end
         REG_LEAK_PER_FACE: leak_rate = data[LEAK_W-1:0];
      endcase
   endtask

   // upper bits of a size write are ignored; put junk there now and then
   function automatic logic [CSR_DATA_W-1:0] with_junk(logic [SIZE_W-1:0] dim);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom_range(0, 1) ? $urandom : '0;
      return (junk & ~CSR_DATA_W'(9'h1FF)) | CSR_DATA_W'(dim);
   endfunction

   task automatic set_dims(logic [SIZE_W-1:0] dx, logic [SIZE_W-1:0] dy,
                           logic [SIZE_W-1:0] dz);
      write_reg(REG_SIZE_X, with_junk(dx));
      write_reg(REG_SIZE_Y, with_junk(dy));
      write_reg(REG_SIZE_Z, with_junk(dz));
   endtask

   task automatic queue_voxels(int unsigned count, int unsigned sand_pct);
      repeat (count)
         voxel_queue.push_back(($urandom_range(0, 99) < sand_pct) ?
                               VOXEL_W'($urandom_range(1, 255)) : {VOXEL_W{1'b0}});
   endtask

   task automatic wait_drained();
      int unsigned spins;
      spins = 0;
      while ((voxel_queue.size() != 0 || req_bus.valid || face_expect.size() != 0)
             && spins < DRAIN_LIMIT) begin
         @(posedge clock);
         spins++;
      end
      if (face_expect.size() != 0) begin
         report_fault($sformatf("%0d results never arrived", face_expect.size()));
         face_expect.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic run_volume(logic [SIZE_W-1:0] dx, logic [SIZE_W-1:0] dy,
                             logic [SIZE_W-1:0] dz, int unsigned count,
                             inout int unsigned spent);
      set_dims(dx, dy, dz);
      write_reg(REG_LEAK_PER_FACE, pick_leak());
      queue_voxels(count, $urandom_range(20, 80));
      wait_drained();
      spent += count;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.voxel <= '0;
         tx_wait = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            face_expect.push_back(scan_voxel(req_bus.voxel));
         if (!req_bus.valid || req_bus.ready) begin
            if (tx_wait > 0) begin
               tx_wait--;
               req_bus.valid <= 1'b0;
            end else if (voxel_queue.size() > 0) begin
               req_bus.valid <= 1'b1;
               req_bus.voxel <= voxel_queue.pop_front();
               tx_wait = tx_calm ? 0 : $urandom_range(0, 8);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_count++;
            if (face_expect.size() == 0) begin
               report_fault($sformatf("result %0d with no transaction pending",
                                      result_count));
            end else begin
               want = face_expect.pop_front();
               if (rsp_bus.is_sand !== want.is_sand || rsp_bus.new_faces !== want.new_faces
                   || rsp_bus.face_total !== want.face_total
                   || rsp_bus.leak_total !== want.leak_total || rsp_bus.last !== want.last)
                  report_fault($sformatf({"result %0d: expected sand=%0d new=%0d ",
                     "total=%0d leak=%0h last=%0d, got sand=%0d new=%0d total=%0d ",
                     "leak=%0h last=%0d"}, result_count, want.is_sand, want.new_faces,
                     want.face_total, want.leak_total, want.last, rsp_bus.is_sand,
                     rsp_bus.new_faces, rsp_bus.face_total, rsp_bus.leak_total,
                     rsp_bus.last));
            end
            rx_wait = rx_calm ? 0 : $urandom_range(0, 8);
         end
         if (rx_hold) begin
            rsp_bus.ready <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned       spent, vol, n;
      logic [SIZE_W-1:0] dx, dy, dz;
      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_index     <= REG_SIZE_X;
      csr_wdata     <= '0;
      rx_hold       <= 1'b0;
      tx_calm       <= 1'b0;
      rx_calm       <= 1'b0;
      dim_raw[0] = 1;
      dim_raw[1] = 1;
      dim_raw[2] = 1;
      leak_rate = '0;
      clear_scan();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: every voxel is a whole volume
      voxel_queue.push_back(8'h00);
      voxel_queue.push_back(8'hFF);
      wait_drained();

      set_dims(2, 2, 2);
      write_reg(REG_LEAK_PER_FACE, '1);
      foreach (CHECKER[i]) voxel_queue.push_back(CHECKER[i]);
      wait_drained();

      // zero size acts as one, bit 9 is dropped, oversize clamps to the maximum
      write_reg(REG_SIZE_X, 32'h0);
      write_reg(REG_SIZE_Y, 32'h202);
      write_reg(REG_SIZE_Z, 32'h1FF);
      queue_voxels(5, 50);
      wait_drained();
      // size write part way through a volume restarts it
      write_reg(REG_SIZE_Z, 32'd3);
      queue_voxels(6, 50);
      wait_drained();

      // leak change keeps the running count
      set_dims(1, 1, 4);
      write_reg(REG_LEAK_PER_FACE, 32'd5);
      voxel_queue.push_back(8'h00);
      voxel_queue.push_back(8'h01);
      wait_drained();
      write_reg(REG_LEAK_PER_FACE, 32'h8000_0000);
      voxel_queue.push_back(8'h00);
      voxel_queue.push_back(8'hFE);
      wait_drained();

      spent = 0;
      run_volume(1, 1, 256, 256, spent);
      run_volume(1, 256, 1, 256, spent);
      run_volume(256, 1, 1, 256, spent);
      // only the start of a full-size volume; the next size write restarts it
      run_volume(256, 256, 256, 300, spent);

      // long receiver stall while the sender keeps offering
      set_dims(4, 4, 8);
      tx_calm <= 1'b1;
      rx_calm <= 1'b1;
      queue_voxels(128, 50);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rx_hold <= 1'b0;
      wait_drained();
      spent += 128;

      while (spent < RANDOM_ITEMS) begin
         tx_calm <= ($urandom_range(0, 3) == 0);
         rx_calm <= ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 4))
            0: ;
            1: write_reg(REG_LEAK_PER_FACE, pick_leak());
            default: begin
               dx = $urandom_range(1, 5);
               dy = $urandom_range(1, 5);
               dz = $urandom_range(1, 5);
               case ($urandom_range(0, 5))
                  0: dx = $urandom_range(7, 16);
                  1: dy = $urandom_range(7, 16);
                  2: dz = $urandom_range(7, 16);
                  3: dz = 0;
                  default: ;
               endcase
               set_dims(dx, dy, dz);
               write_reg(REG_LEAK_PER_FACE, pick_leak());
            end
         endcase
         vol = eff_dim(dim_raw[0]) * eff_dim(dim_raw[1]) * eff_dim(dim_raw[2]);
         n = vol * $urandom_range(1, 3);
         if (n > 400) n = vol;
         if ($urandom_range(0, 2) == 0) n += $urandom_range(1, vol);
         queue_voxels(n, $urandom_range(0, 100));
         wait_drained();
         spent += n;
      end

      wait_drained();
      if (fault_count == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/vscfc_pkg.sv
hw/rtl/vscfc_req_if.sv
hw/rtl/vscfc_rsp_if.sv
hw/rtl/vscfc_ram.sv
hw/rtl/vscfc_scan.sv
hw/rtl/vscfc_tally.sv
hw/rtl/voxel_sand_cavity_face_counter.sv
hw/rtl/vscfc_checker.sv
test/tb_top.sv
